// ===== hdl/slcs_pkg.sv =====
// Shared constants and types for the set-associative LRU cache statistics unit.
`default_nettype none
package slcs_pkg;
    // configuration register indexes
    localparam logic [1:0] CFG_SET_BITS   = 2'd0;
    localparam logic [1:0] CFG_BLOCK_BITS = 2'd1;
    localparam logic [1:0] CFG_WAYS       = 2'd2;

    localparam logic [3:0] MAX_BLOCK_BITS = 4'd12;
    localparam logic [11:0] DLINE_MAX     = 12'hFFF;
    localparam logic [35:0] DEVICT_MAX    = 36'hF_FFFF_FFFF;
    localparam logic [31:0] SAT32         = 32'hFFFF_FFFF;

    // per-access outcome from the set update logic
    typedef struct packed {
        logic hit;
        logic evicted;
        logic dirty_evicted;
        logic dirty_inc;
        logic dirty_dec;
    } upd_flags_t;
endpackage
`default_nettype wire

// ===== hdl/slcs_set_update.sv =====
// Lookup, victim choice and LRU rank update for one cache set.
`default_nettype none
module slcs_set_update #(
    parameter int MAX_WAYS = 8,
    parameter int TAG_W    = 64,
    parameter int RANK_W   = 3,
    parameter int WAY_CW   = 4
) (
    input  wire logic [MAX_WAYS-1:0]             valid_i,
    input  wire logic [MAX_WAYS-1:0]             dirty_i,
    input  wire logic [MAX_WAYS-1:0][RANK_W-1:0] rank_i,
    input  wire logic [MAX_WAYS-1:0][TAG_W-1:0]  tag_i,
    input  wire logic [WAY_CW-1:0]               nw_i,
    input  wire logic                            store_i,
    input  wire logic [TAG_W-1:0]                tag_new_i,
    output      logic [MAX_WAYS-1:0]             valid_o,
    output      logic [MAX_WAYS-1:0]             dirty_o,
    output      logic [MAX_WAYS-1:0][RANK_W-1:0] rank_o,
    output      logic [MAX_WAYS-1:0][TAG_W-1:0]  tag_o,
    output      slcs_pkg::upd_flags_t            flags_o
);
    import slcs_pkg::*;

    localparam int WAY_IW = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
    localparam logic [RANK_W-1:0] RANK_TOP = RANK_W'(MAX_WAYS - 1);

    logic [MAX_WAYS-1:0] in_use;
    logic                hit;
    logic [WAY_IW-1:0]   hit_way;
    logic                free_found;
    logic [WAY_IW-1:0]   free_way;
    logic [WAY_IW-1:0]   vic_way;
    logic [WAY_IW-1:0]   sel;
    logic                unbounded;
    logic [RANK_W-1:0]   r;
    logic                d_old;

    // hit search and first free line, lowest way wins
    always_comb begin
        hit        = 1'b0;
        hit_way    = '0;
        free_found = 1'b0;
        free_way   = '0;
        for (int i = MAX_WAYS - 1; i >= 0; i--) begin
            in_use[i] = (WAY_CW'(i) < nw_i);
            if (in_use[i] && valid_i[i] && tag_i[i] == tag_new_i) begin
                hit     = 1'b1;
                hit_way = WAY_IW'(i);
            end
            if (in_use[i] && !valid_i[i]) begin
                free_found = 1'b1;
                free_way   = WAY_IW'(i);
            end
        end
    end

    // victim: highest rank, ties to the lowest way
    always_comb begin
        vic_way = '0;
        for (int i = 1; i < MAX_WAYS; i++) begin
            if (in_use[i] && rank_i[i] > rank_i[vic_way]) vic_way = WAY_IW'(i);
        end
    end

    always_comb begin
        sel       = hit ? hit_way : (free_found ? free_way : vic_way);
        unbounded = !hit && free_found;
        r         = rank_i[sel];
        d_old     = dirty_i[sel];
    end

    // new set contents
    always_comb begin
        valid_o = valid_i;
        dirty_o = dirty_i;
        tag_o   = tag_i;
        for (int i = 0; i < MAX_WAYS; i++) begin
            if (WAY_IW'(i) == sel) begin
                rank_o[i] = '0;
            end else if (in_use[i] && valid_i[i] && (unbounded || rank_i[i] < r)
                         && rank_i[i] != RANK_TOP) begin
                rank_o[i] = rank_i[i] + 1'b1;
            end else begin
                rank_o[i] = rank_i[i];
            end
        end
        valid_o[sel] = 1'b1;
        dirty_o[sel] = hit ? (d_old | store_i) : store_i;
        if (!hit) tag_o[sel] = tag_new_i;
    end

    always_comb begin
        flags_o.hit           = hit;
        flags_o.evicted       = !hit && !free_found;
        flags_o.dirty_evicted = !hit && !free_found && d_old;
        flags_o.dirty_inc     = store_i && !d_old;
        flags_o.dirty_dec     = !store_i && d_old && !hit && !free_found;
    end
endmodule
`default_nettype wire

// ===== hdl/set_assoc_lru_cache_stats_unit.sv =====
// Top level: set-associative write-back LRU cache model with running statistics.
// Usage:
//   Input channel s_valid/s_ready carries one access (s_kind: 0 load, 1 store,
//   s_address). Result channel m_valid/m_ready returns one item per access:
//   hit/evicted/dirty_evicted flags and the totals after that access.
//   Configuration (set_bits, block_bits, ways) is written through cfg_we,
//   cfg_index and cfg_wdata while no access is in flight.
//   Each set lives in one row of a memory with a registered read.
//   An accepted access reads its set row at the accepting edge; in ST_CALC
//   it updates tags, dirty bits and LRU ranks, writes the row back and loads
//   the result register, which m_valid then shows; a new access is taken
//   only after ST_CALC has finished with the previous one.
//   A new access is taken while a result waits; if the receiver still stalls
//   when the next update is ready, that update holds until the result drains.
//   Reset clears counters and per-row init flags and loads the default
//   configuration at once; an uninitialized row reads as all lines invalid,
//   clean, rank zero. No clearing pass is needed.
`default_nettype none
module set_assoc_lru_cache_stats_unit #(
    parameter int MAX_SET_BITS = 8,
    parameter int MAX_WAYS     = 8,
    parameter int ADDR_WIDTH   = 64
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_valid,
    output      logic        s_ready,
    input  wire logic        s_kind,
    input  wire logic [63:0] s_address,
    output      logic        m_valid,
    input  wire logic        m_ready,
    output      logic        m_hit,
    output      logic        m_evicted,
    output      logic        m_dirty_evicted,
    output      logic [31:0] m_hit_count,
    output      logic [31:0] m_miss_count,
    output      logic [31:0] m_eviction_count,
    output      logic [23:0] m_dirty_held_bytes,
    output      logic [47:0] m_dirty_evicted_bytes,
    input  wire logic        cfg_we,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [3:0]  cfg_wdata
);
    import slcs_pkg::*;

    localparam int ROWS   = 1 << MAX_SET_BITS;
    localparam int SET_IW = (MAX_SET_BITS > 0) ? MAX_SET_BITS : 1;
    localparam int RANK_W = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
    localparam int WAY_CW = $clog2(MAX_WAYS + 1);
    localparam int TAG_W  = ADDR_WIDTH;
    localparam int ROW_W  = MAX_WAYS * (2 + RANK_W + TAG_W);

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_CALC = 1'b1;

    typedef struct packed {
        logic [MAX_WAYS-1:0]             valid;
        logic [MAX_WAYS-1:0]             dirty;
        logic [MAX_WAYS-1:0][RANK_W-1:0] rank;
        logic [MAX_WAYS-1:0][TAG_W-1:0]  tag;
    } row_t;

    logic [ROW_W-1:0]  mem [ROWS];
    logic [ROWS-1:0]   row_init_reg;
    row_t              rd_row_reg;
    logic              rd_init_reg;
    row_t              cur_row, new_row;
    upd_flags_t        flags;

    logic              state_reg;
    logic [3:0]        set_bits_reg, block_bits_reg, ways_reg;
    logic [SET_IW-1:0] set_reg;
    logic [TAG_W-1:0]  tag_reg;
    logic              store_reg;

    logic [31:0]       hit_total_reg, miss_total_reg, evict_total_reg;
    logic [11:0]       dline_reg;
    logic [35:0]       devict_reg;
    logic [31:0]       hit_total_next, miss_total_next, evict_total_next;
    logic [11:0]       dline_next;
    logic [35:0]       devict_next;

    logic              m_valid_reg;
    logic              hit_reg, evicted_reg, dev_reg;
    logic [31:0]       hit_cnt_reg, miss_cnt_reg, evict_cnt_reg;
    logic [23:0]       dbytes_reg;
    logic [47:0]       debytes_reg;

    logic [3:0]        sb, bb;
    logic [WAY_CW-1:0] nw;
    logic [4:0]        sh;
    logic [TAG_W-1:0]  addr_a, blk;
    logic [SET_IW-1:0] set_idx;
    logic              accept, commit;

    // clamp configuration
    always_comb begin
        sb = (set_bits_reg > 4'(MAX_SET_BITS)) ? 4'(MAX_SET_BITS) : set_bits_reg;
        bb = (block_bits_reg > MAX_BLOCK_BITS) ? MAX_BLOCK_BITS : block_bits_reg;
        if (ways_reg == 4'd0) begin
            nw = WAY_CW'(1);
        end else if ({1'b0, ways_reg} > 5'(MAX_WAYS)) begin
            nw = WAY_CW'(MAX_WAYS);
        end else begin
            nw = WAY_CW'(ways_reg);
        end
    end

    // address split
    always_comb begin
        addr_a  = s_address[ADDR_WIDTH-1:0];
        blk     = addr_a >> bb;
        sh      = {1'b0, sb} + {1'b0, bb};
        set_idx = blk[SET_IW-1:0] & ~({SET_IW{1'b1}} << sb);
    end

    assign s_ready = (state_reg == ST_IDLE);
    assign accept  = s_valid && s_ready;
    assign commit  = (state_reg == ST_CALC) && (!m_valid_reg || m_ready);

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            set_bits_reg   <= 4'd4;
            block_bits_reg <= 4'd4;
            ways_reg       <= 4'd2;
        end else if (cfg_we) begin
            unique case (cfg_index)
                CFG_SET_BITS:   set_bits_reg   <= cfg_wdata;
                CFG_BLOCK_BITS: block_bits_reg <= cfg_wdata;
                CFG_WAYS:       ways_reg       <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // sequencer
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            unique case (state_reg)
                ST_IDLE: if (accept) state_reg <= ST_CALC;
                ST_CALC: if (commit) state_reg <= ST_IDLE;
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    // access latch
    always_ff @(posedge aclk) begin
        if (accept) begin
            set_reg   <= set_idx;
            tag_reg   <= addr_a >> sh;
            store_reg <= s_kind;
        end
    end

    // set memory: read at accept, write back at commit
    always_ff @(posedge aclk) begin
        if (accept) rd_row_reg <= row_t'(mem[set_idx]);
        if (commit) mem[set_reg] <= ROW_W'(new_row);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            row_init_reg <= '0;
            rd_init_reg  <= 1'b0;
        end else begin
            if (accept) rd_init_reg <= row_init_reg[set_idx];
            if (commit) row_init_reg[set_reg] <= 1'b1;
        end
    end

    // a never-written row reads as empty
    always_comb begin
        cur_row     = rd_row_reg;
        if (!rd_init_reg) begin
            cur_row.valid = '0;
            cur_row.dirty = '0;
            cur_row.rank  = '0;
        end
    end

    slcs_set_update #(
        .MAX_WAYS (MAX_WAYS),
        .TAG_W    (TAG_W),
        .RANK_W   (RANK_W),
        .WAY_CW   (WAY_CW)
    ) u_update (
        .valid_i   (cur_row.valid),
        .dirty_i   (cur_row.dirty),
        .rank_i    (cur_row.rank),
        .tag_i     (cur_row.tag),
        .nw_i      (nw),
        .store_i   (store_reg),
        .tag_new_i (tag_reg),
        .valid_o   (new_row.valid),
        .dirty_o   (new_row.dirty),
        .rank_o    (new_row.rank),
        .tag_o     (new_row.tag),
        .flags_o   (flags)
    );

    // saturating totals
    always_comb begin
        hit_total_next   = hit_total_reg;
        miss_total_next  = miss_total_reg;
        evict_total_next = evict_total_reg;
        dline_next       = dline_reg;
        devict_next      = devict_reg;
        if (flags.hit) begin
            if (hit_total_reg != SAT32) hit_total_next = hit_total_reg + 32'd1;
        end else begin
            if (miss_total_reg != SAT32) miss_total_next = miss_total_reg + 32'd1;
        end
        if (flags.evicted && evict_total_reg != SAT32)
            evict_total_next = evict_total_reg + 32'd1;
        if (flags.dirty_evicted && devict_reg != DEVICT_MAX)
            devict_next = devict_reg + 36'd1;
        if (flags.dirty_inc && dline_reg != DLINE_MAX)
            dline_next = dline_reg + 12'd1;
        else if (flags.dirty_dec && dline_reg != 12'd0)
            dline_next = dline_reg - 12'd1;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hit_total_reg   <= '0;
            miss_total_reg  <= '0;
            evict_total_reg <= '0;
            dline_reg       <= '0;
            devict_reg      <= '0;
        end else if (commit) begin
            hit_total_reg   <= hit_total_next;
            miss_total_reg  <= miss_total_next;
            evict_total_reg <= evict_total_next;
            dline_reg       <= dline_next;
            devict_reg      <= devict_next;
        end
    end

    // result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (commit) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (commit) begin
            hit_reg       <= flags.hit;
            evicted_reg   <= flags.evicted;
            dev_reg       <= flags.dirty_evicted;
            hit_cnt_reg   <= hit_total_next;
            miss_cnt_reg  <= miss_total_next;
            evict_cnt_reg <= evict_total_next;
            dbytes_reg    <= {12'd0, dline_next} << bb;
            debytes_reg   <= {12'd0, devict_next} << bb;
        end
    end

    assign m_valid               = m_valid_reg;
    assign m_hit                 = hit_reg;
    assign m_evicted             = evicted_reg;
    assign m_dirty_evicted       = dev_reg;
    assign m_hit_count           = hit_cnt_reg;
    assign m_miss_count          = miss_cnt_reg;
    assign m_eviction_count      = evict_cnt_reg;
    assign m_dirty_held_bytes    = dbytes_reg;
    assign m_dirty_evicted_bytes = debytes_reg;

    // checks
    a_hit_no_evict: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg |-> !(hit_reg && evicted_reg))
        else $error("hit and eviction reported together");

    a_dev_needs_evict: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && dev_reg) |-> evicted_reg)
        else $error("dirty eviction without eviction");

    a_commit_loads_result: assert property (@(posedge aclk) disable iff (!aresetn)
        commit |=> (m_valid_reg && state_reg == ST_IDLE))
        else $error("commit did not load the result");

    a_no_accept_in_calc: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_CALC && !commit) |=> (state_reg == ST_CALC && $stable(set_reg)))
        else $error("stalled update lost its set");
endmodule
`default_nettype wire
